@@ rtl/knn_pkg.sv @@
package knn_pkg;

  localparam int WEIGHT_BITS = 24;
  localparam int VALUE_W     = 32;
  localparam int DIST_W      = 64;
  localparam int USED_W      = 5;

  typedef enum logic [1:0] {
    ACT_REF   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [1:0] REG_NUM_FEATURES = 2'd0;
  localparam logic [1:0] REG_K_COUNT      = 2'd1;
  localparam logic [1:0] REG_PATH_MODE    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_DRAIN,
    ST_WSTART,
    ST_WWAIT,
    ST_MAC,
    ST_ACC,
    ST_MSTART,
    ST_MWAIT,
    ST_OUT
  } state_t;

  // divider request: start pulse and mode (ratio or rounded mean)
  typedef struct packed {
    logic start;
    logic ratio;
  } div_req_t;

  // one finished row distance going into the nearest list
  typedef struct packed {
    logic                      valid;
    logic [DIST_W-1:0]         row_dist;
    logic signed [VALUE_W-1:0] tgt;
  } near_ins_t;

endpackage

@@ rtl/knn_div.sv @@
module knn_div import knn_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  div_req_t     req,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] q
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  r;
  logic [W-1:0]  n;
  logic [W-1:0]  d;
  logic [W:0]    rs;
  logic          ge;
  logic [W:0]    rdiff;

  // one restoring step: shift next dividend bit in, subtract if it fits
  assign rs    = {r, n[W-1]};
  assign ge    = rs >= {1'b0, d};
  assign rdiff = rs - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        if (req.ratio) begin
          cnt <= CW'(WEIGHT_BITS);
        end else begin
          cnt <= CW'(W);
        end
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      d <= b;
      if (req.ratio) begin
        // integer part of a/b (0 or 1), then fraction bits
        r <= (a >= b) ? a - b : a;
        q <= W'(a >= b);
        n <= '0;
      end else begin
        r <= '0;
        q <= '0;
        n <= a;
      end
    end else if (busy) begin
      r <= ge ? rdiff[W-1:0] : rs[W-1:0];
      q <= {q[W-2:0], ge};
      n <= {n[W-2:0], 1'b0};
    end
  end

endmodule

@@ rtl/knn_nearest.sv @@
module knn_nearest import knn_pkg::*; #(
  parameter int K_MAX = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic [$clog2(K_MAX+1)-1:0]     keff,
  input  near_ins_t                      ins,
  input  logic [(K_MAX > 1 ? $clog2(K_MAX) : 1)-1:0] sel,
  output logic [DIST_W-1:0]              head_dist,
  output logic [DIST_W-1:0]              sel_dist,
  output logic signed [VALUE_W-1:0]      sel_tgt
);

  localparam int KW  = $clog2(K_MAX + 1);
  localparam int KIW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic [DIST_W-1:0]         dists [K_MAX];
  logic signed [VALUE_W-1:0] tgt  [K_MAX];
  logic [KW-1:0]             filled;
  logic [K_MAX-1:0]          le;
  logic                      room;
  logic                      do_ins;
  logic [KIW-1:0]            tail;

  // each cell flags whether it stays ahead of the new row (ties stay ahead)
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      le[i] = (KW'(i) < filled) && (dists[i] <= ins.row_dist);
    end
  end

  assign tail   = KIW'(keff - 1'b1);
  assign room   = filled < keff;
  assign do_ins = ins.valid && (room || !le[tail]);

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (clear) begin
      filled <= '0;
    end else if (do_ins && room) begin
      filled <= filled + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (!le[i]) begin
          if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
            dists[i] <= ins.row_dist;
            tgt[i]   <= ins.tgt;
          end else begin
            dists[i] <= dists[(i == 0) ? 0 : i-1];
            tgt[i]   <= tgt[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  assign head_dist = dists[0];
  assign sel_dist  = dists[sel];
  assign sel_tgt   = tgt[sel];

endmodule

@@ rtl/knn_inverse_distance_regressor.sv @@
// k-nearest-neighbor regressor with inverse-distance weights. Requests on the
// input stream carry action in tuser (0 reference feature, 1 query feature,
// 2 clear store) and value/target in tdata; a reference row's target is taken
// on its last feature. Reference features are taken while the block is idle.
// The last query feature starts a scan: one feature of one stored row per
// cycle through a memory read, a 32x32 multiplier and a saturating 64-bit
// accumulator. Each row distance is sorted into a row of compare cells. Then
// for each of k_eff neighbors a shared restoring divider forms the weight,
// which is multiplied into the weighted sums, and, for each emitted mean, the
// rounded quotient; results wait in an output register. The block takes no
// request from the end of a query's last feature until its last result is
// taken.
// Distances are Q32.32 sums of d*d+|d|, saturating; zero becomes one LSB.
// With no rows stored a query returns one result with status 1.
module knn_inverse_distance_regressor import knn_pkg::*; #(
  parameter int MAX_REFS     = 1024,
  parameter int MAX_FEATURES = 16,
  parameter int K_MAX        = 16
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value[31:0], target[63:32]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // prediction[31:0], neighbours_used[36:32]
  output logic        m_axis_tuser,   // status[0]
  output logic        m_axis_tlast
);

  localparam int CW   = $clog2(MAX_REFS + 1);
  localparam int RW   = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int FW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int NFW  = $clog2(MAX_FEATURES + 1);
  localparam int AW   = (MAX_REFS * MAX_FEATURES > 1) ? $clog2(MAX_REFS * MAX_FEATURES) : 1;
  localparam int KW   = $clog2(K_MAX + 1);
  localparam int KIW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int WW   = WEIGHT_BITS + 1;
  localparam int PW   = VALUE_W + WW + 1;
  localparam int SYW  = PW + KW;
  localparam int SWW  = WW + KW;
  localparam int DW   = (SYW + 1 > DIST_W) ? SYW + 1 : DIST_W;

  state_t state, state_next;

  // config registers
  logic [4:0] num_features;
  logic [4:0] k_count;
  logic       path_mode;

  // row loading
  logic [CW-1:0] ref_count;
  logic [FW-1:0] pos;
  logic          kind;

  // stores
  logic signed [VALUE_W-1:0] feat_mem [MAX_REFS * MAX_FEATURES];
  logic signed [VALUE_W-1:0] tgt_mem  [MAX_REFS];
  logic signed [VALUE_W-1:0] qbuf     [MAX_FEATURES];
  logic signed [VALUE_W-1:0] feat_rd;
  logic signed [VALUE_W-1:0] tgt_rd;

  // request decode
  logic                      s_acc;
  logic [1:0]                act;
  logic signed [VALUE_W-1:0] in_value;
  logic signed [VALUE_W-1:0] in_target;
  logic [NFW-1:0]            nf_eff;
  logic [FW-1:0]             p;
  logic                      row_last;
  logic                      q_start;
  logic [KW-1:0]             k_clip;
  logic [KW-1:0]             keff;

  // scan
  logic [NFW-1:0] qlen;
  logic [RW-1:0]  row;
  logic [FW-1:0]  col;
  logic           issue;
  logic           scan_end;
  logic           s1_v, s1_first, s1_last;
  logic [FW-1:0]  s1_j;
  logic           s2_v, s2_first, s2_last;
  logic [DIST_W-1:0]         s2_t1;
  logic [47:0]               s2_t2;
  logic signed [VALUE_W-1:0] s2_tgt;
  logic signed [VALUE_W:0]   diff;
  logic [VALUE_W-1:0]        mag_d;
  logic [DIST_W-1:0]         acc;
  logic [DIST_W+1:0]         acc_sum;
  logic [DIST_W-1:0]         acc_sat;
  near_ins_t                 ins;

  // nearest list
  logic [KW-1:0]             kcur;
  logic [DIST_W-1:0]         head_dist;
  logic [DIST_W-1:0]         sel_dist;
  logic signed [VALUE_W-1:0] sel_tgt;

  // weighting
  div_req_t                  div_req;
  logic [DW-1:0]             div_a, div_b, div_q;
  logic                      div_done;
  logic [WW-1:0]             w;
  logic signed [PW-1:0]      prod;
  logic [SWW-1:0]            sw;
  logic signed [SYW-1:0]     sy;
  logic                      sy_neg;
  logic [SYW-1:0]            sy_mag;
  logic [DW-1:0]             num;
  logic                      emit;
  logic                      k_last;
  logic [VALUE_W-1:0]        q_clamp;
  logic [VALUE_W-1:0]        pred;

  // output register
  logic [VALUE_W-1:0] out_pred;
  logic [USED_W-1:0]  out_used;
  logic               out_status;
  logic               out_last;
  logic               m_acc;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_features <= 5'd1;
      k_count      <= 5'd1;
      path_mode    <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_NUM_FEATURES: num_features <= pwdata[4:0];
        REG_K_COUNT:      k_count      <= pwdata[4:0];
        REG_PATH_MODE:    path_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NUM_FEATURES: prdata = {27'd0, num_features};
      REG_K_COUNT:      prdata = {27'd0, k_count};
      REG_PATH_MODE:    prdata = {31'd0, path_mode};
      default:          prdata = 32'd0;
    endcase
  end

  // request decode
  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign act       = s_axis_tuser;
  assign in_value  = s_axis_tdata[31:0];
  assign in_target = s_axis_tdata[63:32];

  always_comb begin
    if (num_features == 5'd0) begin
      nf_eff = NFW'(1);
    end else if (int'(num_features) > MAX_FEATURES) begin
      nf_eff = NFW'(MAX_FEATURES);
    end else begin
      nf_eff = NFW'(num_features);
    end
    if (k_count == 5'd0) begin
      k_clip = KW'(1);
    end else if (int'(k_count) > K_MAX) begin
      k_clip = KW'(K_MAX);
    end else begin
      k_clip = KW'(k_count);
    end
    keff = (int'(ref_count) < int'(k_clip)) ? KW'(ref_count) : k_clip;
  end

  // a row of the other kind in progress is dropped
  assign p        = (pos != '0 && act[0] != kind) ? '0 : pos;
  assign row_last = int'(p) + 1 >= int'(nf_eff);
  assign q_start  = s_acc && act == ACT_QUERY && row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
      pos       <= '0;
      kind      <= 1'b0;
    end else if (s_acc) begin
      if (act == ACT_CLEAR) begin
        ref_count <= '0;
        pos       <= '0;
      end else if (act == ACT_REF || act == ACT_QUERY) begin
        kind <= act[0];
        pos  <= row_last ? '0 : p + 1'b1;
        if (act == ACT_REF && row_last && int'(ref_count) < MAX_REFS) begin
          ref_count <= ref_count + 1'b1;
        end
      end
    end
  end

  // memories: write on reference features, registered read during scan
  always_ff @(posedge clk) begin
    if (s_acc && act == ACT_REF && int'(ref_count) < MAX_REFS) begin
      feat_mem[AW'(int'(ref_count) * MAX_FEATURES + int'(p))] <= in_value;
      if (row_last) begin
        tgt_mem[RW'(ref_count)] <= in_target;
      end
    end
    feat_rd <= feat_mem[AW'(int'(row) * MAX_FEATURES + int'(col))];
    tgt_rd  <= tgt_mem[row];
  end

  always_ff @(posedge clk) begin
    if (s_acc && act == ACT_QUERY) begin
      qbuf[p] <= in_value;
    end
  end

  // scan counters
  assign scan_end = (int'(row) == int'(ref_count) - 1) && (int'(col) == int'(qlen) - 1);

  always_ff @(posedge clk) begin
    if (q_start) begin
      qlen <= NFW'(int'(p) + 1);
      row  <= '0;
      col  <= '0;
    end else if (issue) begin
      if (int'(col) == int'(qlen) - 1) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // distance pipeline: read, square, accumulate
  assign diff  = {feat_rd[VALUE_W-1], feat_rd} - {qbuf[s1_j][VALUE_W-1], qbuf[s1_j]};
  assign mag_d = diff[VALUE_W] ? VALUE_W'(-diff) : diff[VALUE_W-1:0];

  assign acc_sum = (s2_first ? {(DIST_W+2){1'b0}} : {2'b00, acc})
                 + {2'b00, s2_t1} + (DIST_W+2)'(s2_t2);
  assign acc_sat = (acc_sum[DIST_W+1:DIST_W] != 2'b00) ? {DIST_W{1'b1}}
                                                       : acc_sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      ins.valid <= 1'b0;
    end else begin
      s1_v      <= issue;
      s2_v      <= s1_v;
      ins.valid <= s2_v && s2_last;
      if (s2_v) begin
        ins.row_dist <= (acc_sat == '0) ? DIST_W'(1) : acc_sat;
        ins.tgt      <= s2_tgt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= col == '0;
    s1_last  <= int'(col) == int'(qlen) - 1;
    s1_j     <= col;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_t1    <= DIST_W'(mag_d) * DIST_W'(mag_d);
    s2_t2    <= {mag_d, 16'd0};
    s2_tgt   <= tgt_rd;
    if (s2_v) begin
      acc <= acc_sat;
    end
  end

  knn_nearest #(.K_MAX(K_MAX)) u_nearest (
    .clk       (clk),
    .rst       (rst),
    .clear     (q_start),
    .keff      (keff),
    .ins       (ins),
    .sel       (kcur[KIW-1:0]),
    .head_dist (head_dist),
    .sel_dist  (sel_dist),
    .sel_tgt   (sel_tgt)
  );

  // weights and means
  assign sy_neg = sy < 0;
  assign sy_mag = sy_neg ? SYW'(-sy) : SYW'(sy);
  assign num    = DW'(sy_mag) + DW'(sw >> 1);
  assign k_last = kcur + 1'b1 == keff;
  assign emit   = path_mode || k_last;

  always_comb begin
    if (!sy_neg && div_q > DW'(32'h7FFF_FFFF)) begin
      q_clamp = 32'h7FFF_FFFF;
    end else if (sy_neg && div_q > DW'(32'h8000_0000)) begin
      q_clamp = 32'h8000_0000;
    end else begin
      q_clamp = div_q[VALUE_W-1:0];
    end
    pred = sy_neg ? -q_clamp : q_clamp;
  end

  always_comb begin
    if (state == ST_WSTART) begin
      div_a = DW'(head_dist);
      div_b = DW'(sel_dist);
    end else begin
      div_a = num;
      div_b = DW'(sw);
    end
  end

  knn_div #(.W(DW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .a    (div_a),
    .b    (div_b),
    .done (div_done),
    .q    (div_q)
  );

  always_ff @(posedge clk) begin
    if (q_start) begin
      kcur <= '0;
      sw   <= '0;
      sy   <= '0;
    end else begin
      if (state == ST_WWAIT && div_done) begin
        w <= div_q[WW-1:0];
      end
      if (state == ST_MAC) begin
        prod <= PW'(sel_tgt) * $signed({1'b0, w});
        sw   <= sw + SWW'(w);
      end
      if (state == ST_ACC) begin
        sy <= sy + SYW'(prod);
        if (!emit) begin
          kcur <= kcur + 1'b1;
        end
      end
      if (state == ST_OUT && m_acc && !out_last) begin
        kcur <= kcur + 1'b1;
      end
    end
  end

  // result register
  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (q_start && ref_count == '0) begin
      m_axis_tvalid <= 1'b1;
    end else if (state == ST_MWAIT && div_done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_acc) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_start && ref_count == '0) begin
      out_pred   <= '0;
      out_used   <= '0;
      out_status <= 1'b1;
      out_last   <= 1'b1;
    end else if (state == ST_MWAIT && div_done) begin
      out_pred   <= pred;
      out_used   <= USED_W'(kcur + 1'b1);
      out_status <= 1'b0;
      out_last   <= k_last;
    end
  end

  assign m_axis_tdata = {3'd0, out_used, out_pred};
  assign m_axis_tuser = out_status;
  assign m_axis_tlast = out_last;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_start) begin
          state_next = (ref_count == '0) ? ST_OUT : ST_DIST;
        end
      end
      ST_DIST: begin
        if (scan_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!(s1_v || s2_v || ins.valid)) state_next = ST_WSTART;
      end
      ST_WSTART: state_next = ST_WWAIT;
      ST_WWAIT: begin
        if (div_done) state_next = ST_MAC;
      end
      ST_MAC: state_next = ST_ACC;
      ST_ACC: state_next = emit ? ST_MSTART : ST_WSTART;
      ST_MSTART: state_next = ST_MWAIT;
      ST_MWAIT: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_acc) state_next = out_last ? ST_IDLE : ST_WSTART;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state == ST_IDLE;
    issue         = state == ST_DIST;
    div_req.start = state == ST_WSTART || state == ST_MSTART;
    div_req.ratio = state == ST_WSTART;
  end

endmodule

@@ rtl/knn_checker.sv @@
module knn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a waiting result holds still
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no new request while a query is still answering
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("ready while a result is pending");

  // empty store: single zero result
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[36:0] == 37'd0)
    else $error("bad empty-store result");

  // a good result always uses at least one neighbor
  a_used: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[36:32] != 5'd0)
    else $error("zero neighbors on ok result");

endmodule

bind knn_inverse_distance_regressor knn_checker u_knn_checker (.*);
